@@ rtl/core/odo_pkg.sv @@
package odo_pkg;

   // Default configuration
   localparam int POS_WIDTH_DEF   = 32;
   localparam int ANGLE_WIDTH_DEF = 16;

   // Shared multiplier: 33-bit signed by 17-bit signed
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 17;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Rounded position step, (sum * dt) / 2^31
   localparam int DELTA_W = 19;

   // CORDIC datapath, Q2.30 with headroom
   localparam int CORDIC_STEPS = 16;
   localparam int CORDIC_W     = 34;
   localparam int ITER_W       = $clog2(CORDIC_STEPS);
   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

   typedef struct packed {
      logic signed [15:0] vel_x;
      logic signed [15:0] vel_y;
      logic signed [15:0] yaw_rate;
      logic [15:0]        dt_ticks;
      logic               walking;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [15:0]        heading_out;
      logic               saturated;
   } rsp_payload_type;

   // atan(2^-i) as a 32-bit binary angle
   function automatic logic signed [CORDIC_W-1:0] atan_turn(input logic [ITER_W-1:0] idx);
      logic signed [CORDIC_W-1:0] val;
      unique case (idx)
         4'd0:  val = 34'sd536870912;
         4'd1:  val = 34'sd316933406;
         4'd2:  val = 34'sd167458907;
         4'd3:  val = 34'sd85004756;
         4'd4:  val = 34'sd42667331;
         4'd5:  val = 34'sd21354465;
         4'd6:  val = 34'sd10679838;
         4'd7:  val = 34'sd5340245;
         4'd8:  val = 34'sd2670163;
         4'd9:  val = 34'sd1335087;
         4'd10: val = 34'sd667544;
         4'd11: val = 34'sd333772;
         4'd12: val = 34'sd166886;
         4'd13: val = 34'sd83443;
         4'd14: val = 34'sd41722;
         4'd15: val = 34'sd20861;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

@@ rtl/core/odo_mul.sv @@
module odo_mul import odo_pkg::*; (
   input  logic                      clock,
   input  logic signed [MUL_A_W-1:0] op_a,
   input  logic signed [MUL_B_W-1:0] op_b,
   output logic signed [MUL_P_W-1:0] prod
);

   logic signed [MUL_P_W-1:0] prod_ff;
   logic signed [MUL_P_W-1:0] prod_in;

   // Registered signed product, one operand pair per cycle
   always_comb begin
      prod_in = op_a * op_b;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

@@ rtl/core/odo_cordic.sv @@
module odo_cordic import odo_pkg::*; #(
   parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [ANGLE_WIDTH-1:0] angle,
   output logic                   done,
   output logic signed [15:0]     cos_q15,
   output logic signed [15:0]     sin_q15
);

   logic                       run_ff, run_in;
   logic                       fin_ff, fin_in;
   logic [ITER_W-1:0]          iter_ff, iter_in;
   logic [1:0]                 quad_ff, quad_in;
   logic signed [CORDIC_W-1:0] x_ff, x_in;
   logic signed [CORDIC_W-1:0] y_ff, y_in;
   logic signed [CORDIC_W-1:0] z_ff, z_in;

   logic [31:0]                t32;
   logic [31:0]                t32_bias;
   logic [31:0]                rem32;
   logic signed [CORDIC_W-1:0] x_sh, y_sh, atan_val;
   logic signed [CORDIC_W:0]   cx, sy;

   // Quadrant split of the 32-bit binary angle
   always_comb begin
      t32      = {angle, {(32-ANGLE_WIDTH){1'b0}}};
      t32_bias = t32 + 32'h2000_0000;
      rem32    = t32 - {t32_bias[31:30], 30'd0};
   end

   // One micro-rotation per cycle through the shared shifter
   always_comb begin
      x_sh     = x_ff >>> iter_ff;
      y_sh     = y_ff >>> iter_ff;
      atan_val = atan_turn(iter_ff);
      run_in   = run_ff;
      fin_in   = 1'b0;
      iter_in  = iter_ff;
      quad_in  = quad_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      if (start) begin
         run_in  = 1'b1;
         iter_in = '0;
         quad_in = t32_bias[31:30];
         x_in    = CORDIC_GAIN;
         y_in    = '0;
         z_in    = {{(CORDIC_W-32){rem32[31]}}, rem32};
      end else if (run_ff) begin
         if (!z_ff[CORDIC_W-1]) begin
            x_in = x_ff - y_sh;
            y_in = y_ff + x_sh;
            z_in = z_ff - atan_val;
         end else begin
            x_in = x_ff + y_sh;
            y_in = y_ff - x_sh;
            z_in = z_ff + atan_val;
         end
         iter_in = iter_ff + 1'b1;
         if (iter_ff == ITER_W'(CORDIC_STEPS - 1)) begin
            run_in = 1'b0;
            fin_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         fin_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         fin_ff <= fin_in;
      end
      iter_ff <= iter_in;
      quad_ff <= quad_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

   // Quadrant fold-back
   always_comb begin
      unique case (quad_ff)
         2'd0: begin
            cx = {x_ff[CORDIC_W-1], x_ff};
            sy = {y_ff[CORDIC_W-1], y_ff};
         end
         2'd1: begin
            cx = -{y_ff[CORDIC_W-1], y_ff};
            sy = {x_ff[CORDIC_W-1], x_ff};
         end
         2'd2: begin
            cx = -{x_ff[CORDIC_W-1], x_ff};
            sy = -{y_ff[CORDIC_W-1], y_ff};
         end
         default: begin
            cx = {y_ff[CORDIC_W-1], y_ff};
            sy = -{x_ff[CORDIC_W-1], x_ff};
         end
      endcase
   end

   // Q2.30 to Q1.15, round half up, clamp
   function automatic logic signed [15:0] to_q15(input logic signed [CORDIC_W:0] v);
      logic signed [CORDIC_W:0]    sum;
      logic signed [CORDIC_W-15:0] r;
      logic signed [15:0]          res;
      sum = v + (CORDIC_W+1)'(16384);
      r   = sum[CORDIC_W:15];
      if (r > (CORDIC_W-14)'(32767))
         res = 16'sh7FFF;
      else if (r < -(CORDIC_W-14)'(32768))
         res = 16'sh8000;
      else
         res = r[15:0];
      return res;
   endfunction

   assign done    = fin_ff;
   assign cos_q15 = to_q15(cx);
   assign sin_q15 = to_q15(sy);

endmodule

@@ rtl/core/planar_odometry_integrator_unit.sv @@
// A request goes through the heading multiply, the 16-step CORDIC, the rotate and
// scale products on the single shared multiplier and the response load, in order.
// req_stall stays high while a request is in work; the next one is taken only once
// the last pose is loaded, and that load waits while rsp_stall holds a response.
// Reset (synchronous, active high) clears heading, x and y to zero and empties
// the response register.
module planar_odometry_integrator_unit import odo_pkg::*; #(
   parameter int POS_WIDTH   = POS_WIDTH_DEF,
   parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_TH   = 4'd1;
   localparam logic [3:0] S_HEAD = 4'd2;
   localparam logic [3:0] S_CORD = 4'd3;
   localparam logic [3:0] S_M0   = 4'd4;
   localparam logic [3:0] S_M1   = 4'd5;
   localparam logic [3:0] S_M2   = 4'd6;
   localparam logic [3:0] S_M3   = 4'd7;
   localparam logic [3:0] S_M4   = 4'd8;
   localparam logic [3:0] S_M5   = 4'd9;
   localparam logic [3:0] S_M6   = 4'd10;
   localparam logic [3:0] S_M7   = 4'd11;
   localparam logic [3:0] S_OUT  = 4'd12;

   logic [3:0]                  state_ff, state_in;
   logic [ANGLE_WIDTH-1:0]      heading_ff, heading_in;
   logic signed [POS_WIDTH-1:0] pos_x_ff, pos_x_in;
   logic signed [POS_WIDTH-1:0] pos_y_ff, pos_y_in;
   logic                        clip_ff, clip_in;
   logic signed [15:0]          vx_ff, vx_in, vy_ff, vy_in, wz_ff, wz_in;
   logic [15:0]                 dt_ff, dt_in;
   logic signed [15:0]          c_ff, c_in, s_ff, s_in;
   logic signed [MUL_A_W-1:0]   t_ff, t_in, sx_ff, sx_in;
   logic signed [DELTA_W-1:0]   d_ff, d_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   rsp_payload_type             rsp_data_ff, rsp_data_in;

   logic                        req_take;
   logic                        slot_free;
   logic signed [MUL_A_W-1:0]   op_a;
   logic signed [MUL_B_W-1:0]   op_b;
   logic signed [MUL_P_W-1:0]   prod;
   logic signed [MUL_P_W-1:0]   prod_rnd_h, prod_rnd_d;
   logic                        cordic_start, cordic_done;
   logic signed [15:0]          cordic_cos, cordic_sin;
   logic [15:0]                 heading_16;
   logic signed [31:0]          pos_x_32, pos_y_32;

   // Saturating accumulate, shared by x and y
   logic signed [POS_WIDTH-1:0] sat_pos, sat_res;
   logic signed [POS_WIDTH:0]   sat_sum;
   logic                        sat_clip;

   assign req_take  = req_valid && (state_ff == S_IDLE);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);

   // Shared multiplier operand select
   always_comb begin
      op_a = MUL_A_W'(wz_ff);
      op_b = {1'b0, dt_ff};
      unique case (state_ff)
         S_M0: begin op_a = MUL_A_W'(vx_ff); op_b = MUL_B_W'(c_ff); end
         S_M1: begin op_a = MUL_A_W'(vy_ff); op_b = MUL_B_W'(s_ff); end
         S_M2: begin op_a = MUL_A_W'(vx_ff); op_b = MUL_B_W'(s_ff); end
         S_M3: begin op_a = MUL_A_W'(vy_ff); op_b = MUL_B_W'(c_ff); end
         S_M4: begin op_a = sx_ff;            op_b = {1'b0, dt_ff}; end
         S_M5: begin op_a = t_ff;             op_b = {1'b0, dt_ff}; end
         default: begin op_a = MUL_A_W'(wz_ff); op_b = {1'b0, dt_ff}; end
      endcase
   end

   odo_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   // Round half up of the registered product
   assign prod_rnd_h = prod + MUL_P_W'(32768);
   assign prod_rnd_d = prod + (MUL_P_W'(1) <<< 30);

   assign cordic_start = (state_ff == S_HEAD);

   odo_cordic #(
      .ANGLE_WIDTH (ANGLE_WIDTH)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .angle   (heading_in),
      .done    (cordic_done),
      .cos_q15 (cordic_cos),
      .sin_q15 (cordic_sin)
   );

   always_comb begin
      sat_pos  = (state_ff == S_M7) ? pos_y_ff : pos_x_ff;
      sat_sum  = {sat_pos[POS_WIDTH-1], sat_pos} + (POS_WIDTH+1)'(d_ff);
      sat_clip = (sat_sum[POS_WIDTH] != sat_sum[POS_WIDTH-1]);
      if (!sat_clip)
         sat_res = sat_sum[POS_WIDTH-1:0];
      else if (sat_sum[POS_WIDTH])
         sat_res = {1'b1, {(POS_WIDTH-1){1'b0}}};
      else
         sat_res = {1'b0, {(POS_WIDTH-1){1'b1}}};
   end

   // Heading and position views on 16 and 32 bits
   if (ANGLE_WIDTH >= 16) begin : g_head_wide
      assign heading_16 = heading_ff[ANGLE_WIDTH-1 -: 16];
   end else begin : g_head_narrow
      assign heading_16 = {heading_ff, {(16-ANGLE_WIDTH){1'b0}}};
   end

   if (POS_WIDTH >= 32) begin : g_pos_wide
      assign pos_x_32 = pos_x_ff[31:0];
      assign pos_y_32 = pos_y_ff[31:0];
   end else begin : g_pos_narrow
      assign pos_x_32 = {{(32-POS_WIDTH){pos_x_ff[POS_WIDTH-1]}}, pos_x_ff};
      assign pos_y_32 = {{(32-POS_WIDTH){pos_y_ff[POS_WIDTH-1]}}, pos_y_ff};
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      heading_in   = heading_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      clip_in      = clip_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      wz_in        = wz_ff;
      dt_in        = dt_ff;
      c_in         = c_ff;
      s_in         = s_ff;
      t_in         = t_ff;
      sx_in        = sx_ff;
      d_in         = d_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               // Not walking: all velocities count as zero
               vx_in    = req_data.walking ? req_data.vel_x : 16'sd0;
               vy_in    = req_data.walking ? req_data.vel_y : 16'sd0;
               wz_in    = req_data.walking ? req_data.yaw_rate : 16'sd0;
               dt_in    = req_data.dt_ticks;
               clip_in  = 1'b0;
               state_in = S_TH;
            end
         end
         S_TH:   state_in = S_HEAD;
         S_HEAD: begin
            heading_in = heading_ff + prod_rnd_h[16 +: ANGLE_WIDTH];
            state_in   = S_CORD;
         end
         S_CORD: begin
            if (cordic_done) begin
               c_in     = cordic_cos;
               s_in     = cordic_sin;
               state_in = S_M0;
            end
         end
         S_M0: state_in = S_M1;
         S_M1: begin
            t_in     = prod[MUL_A_W-1:0];
            state_in = S_M2;
         end
         S_M2: begin
            sx_in    = t_ff - prod[MUL_A_W-1:0];
            state_in = S_M3;
         end
         S_M3: begin
            t_in     = prod[MUL_A_W-1:0];
            state_in = S_M4;
         end
         S_M4: begin
            t_in     = t_ff + prod[MUL_A_W-1:0];
            state_in = S_M5;
         end
         S_M5: begin
            d_in     = prod_rnd_d[31 +: DELTA_W];
            state_in = S_M6;
         end
         S_M6: begin
            pos_x_in = sat_res;
            clip_in  = clip_ff | sat_clip;
            d_in     = prod_rnd_d[31 +: DELTA_W];
            state_in = S_M7;
         end
         S_M7: begin
            pos_y_in = sat_res;
            clip_in  = clip_ff | sat_clip;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (slot_free) begin
               rsp_data_in.pos_x       = pos_x_32;
               rsp_data_in.pos_y       = pos_y_32;
               rsp_data_in.heading_out = heading_16;
               rsp_data_in.saturated   = clip_ff;
               rsp_valid_in            = 1'b1;
               state_in                = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         heading_ff   <= '0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         clip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         heading_ff   <= heading_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         clip_ff      <= clip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      vx_ff       <= vx_in;
      vy_ff       <= vy_in;
      wz_ff       <= wz_in;
      dt_ff       <= dt_in;
      c_ff        <= c_in;
      s_ff        <= s_in;
      t_ff        <= t_in;
      sx_ff       <= sx_in;
      d_ff        <= d_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ dv/odometry_pose_checker.sv @@
module odometry_pose_checker import odo_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_stall,
   input  req_payload_type req_data,
   input  logic            rsp_valid,
   input  logic            rsp_stall,
   input  rsp_payload_type rsp_data,
   output int unsigned     fail_count,
   output int unsigned     pending_poses
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     POS_W    = POS_WIDTH_DEF;
   localparam int     ANG_W    = ANGLE_WIDTH_DEF;
   localparam longint GAIN_Q30 = 652032874;
   localparam longint POS_MAX  = (longint'(1) << (POS_W - 1)) - 1;
   localparam longint POS_MIN  = -POS_MAX - 1;
   localparam int     MAX_SHOWN = 10;

   // quadrant taken out before the CORDIC rotation
   typedef enum logic [1:0] {QUAD_EAST, QUAD_NORTH, QUAD_WEST, QUAD_SOUTH} quadrant_type;

   // atan(2^-i) as a fraction of a 2^32 turn
   longint arctan_turn [CORDIC_STEPS] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861
   };

   // pose state, mirrors the block
   logic [ANG_W-1:0] heading_q;
   longint           pos_x_q;
   longint           pos_y_q;

   rsp_payload_type  pose_q [$];

   initial fail_count = 0;

   // round half up: floor(v / 2^s + 1/2)
   function automatic longint round_shift(input longint v, input int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint to_q15(input longint v);
      longint r;
      r = round_shift(v, 15);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r;
   endfunction

   function automatic void sine_cosine(input logic [ANG_W-1:0] ang,
                                       output longint cos_q15, output longint sin_q15);
      logic [31:0]  turn32, biased, rest;
      quadrant_type quad;
      longint       z, x, y, xn, cx, sy;
      turn32 = 32'(ang) << (32 - ANG_W);
      biased = turn32 + 32'h2000_0000;
      quad   = quadrant_type'(biased[31:30]);
      rest   = turn32 - {quad, 30'b0};
      z = longint'($signed(rest));
      x = GAIN_Q30;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (z >= 0) begin
            xn = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - arctan_turn[i];
         end else begin
            xn = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + arctan_turn[i];
         end
         x = xn;
      end
      // rotate back by the quadrant
      case (quad)
         QUAD_EAST:  begin cx = x;  sy = y;  end
         QUAD_NORTH: begin cx = -y; sy = x;  end
         QUAD_WEST:  begin cx = -x; sy = -y; end
         default:    begin cx = y;  sy = -x; end
      endcase
      cos_q15 = to_q15(cx);
      sin_q15 = to_q15(sy);
   endfunction

   function automatic longint clamp_add(input longint p, input longint d, output logic hit);
      longint sum;
      sum = p + d;
      hit = 1'b0;
      if (sum > POS_MAX) begin
         sum = POS_MAX;
         hit = 1'b1;
      end
      if (sum < POS_MIN) begin
         sum = POS_MIN;
         hit = 1'b1;
      end
      return sum;
   endfunction

   // one control tick: heading first, then rotate, scale and accumulate
   function automatic rsp_payload_type advance_pose(input req_payload_type tick);
      rsp_payload_type    pose;
      longint             vx, vy, wz, dt, dth, c, s, dx, dy;
      logic               hit_x, hit_y;
      logic [ANG_W+15:0]  wide_heading;
      vx = tick.walking ? longint'(tick.vel_x) : 0;
      vy = tick.walking ? longint'(tick.vel_y) : 0;
      wz = tick.walking ? longint'(tick.yaw_rate) : 0;
      dt = longint'(tick.dt_ticks);
      dth = round_shift(wz * dt, 16);
      heading_q = ANG_W'(longint'(heading_q) + dth);
      sine_cosine(heading_q, c, s);
      dx = round_shift((vx * c - vy * s) * dt, 31);
      dy = round_shift((vx * s + vy * c) * dt, 31);
      pos_x_q = clamp_add(pos_x_q, dx, hit_x);
      pos_y_q = clamp_add(pos_y_q, dy, hit_y);
      // heading rescaled to a 16-bit turn
      wide_heading = {heading_q, 16'b0};
      pose.pos_x       = 32'(pos_x_q);
      pose.pos_y       = 32'(pos_y_q);
      pose.heading_out = wide_heading[ANG_W+15 -: 16];
      pose.saturated   = hit_x | hit_y;
      return pose;
   endfunction

   task automatic check_pose(input rsp_payload_type got);
      rsp_payload_type want;
      if (pose_q.size() == 0) begin
         fail_count++;
         if (fail_count <= MAX_SHOWN)
            $display("%0t: pose with no request pending: x=%0d y=%0d hdg=%0d sat=%0b",
                     $realtime, got.pos_x, got.pos_y, got.heading_out, got.saturated);
      end else begin
         want = pose_q.pop_front();
         if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
             got.heading_out !== want.heading_out || got.saturated !== want.saturated) begin
            fail_count++;
            if (fail_count <= MAX_SHOWN)
               $display({"%0t: pose mismatch: exp x=%0d y=%0d hdg=%0d sat=%0b, ",
                         "got x=%0d y=%0d hdg=%0d sat=%0b"},
                        $realtime, want.pos_x, want.pos_y, want.heading_out, want.saturated,
                        got.pos_x, got.pos_y, got.heading_out, got.saturated);
         end
      end
   endtask

   // watch both channels
   always @(posedge clock) begin
      if (reset) begin
         heading_q = '0;
         pos_x_q   = 0;
         pos_y_q   = 0;
         pose_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) check_pose(rsp_data);
         if (req_valid && !req_stall) pose_q.push_back(advance_pose(req_data));
      end
      pending_poses = pose_q.size();
   end

endmodule

@@ dv/tb_planar_odometry_integrator_unit.sv @@
module tb_planar_odometry_integrator_unit;
   import odo_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_TICKS   = 1100;
   localparam int QUIET_TICKS    = 200;
   localparam int HOLD_AT_TICK   = 600;
   localparam int HOLD_CYCLES    = 400;
   localparam int FAST_RUN_TICKS = 150;
   localparam int TAIL_TICKS     = 75;
   localparam int SETTLE_CYCLES  = 40;
   localparam int IDLE_PERCENT   = 35;
   localparam int HEADING_45DEG  = 8192;
   localparam int DT_FULL        = 65535;
   localparam longint CYCLE_LIMIT = 4_000_000;

   logic            clock     = 1'b0;
   logic            reset     = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_data  = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_data;

   int unsigned     fail_count;
   int unsigned     pending_poses;
   bit              idle_on   = 1'b0;
   bit              hold_req  = 1'b0;
   int unsigned     hold_left = 0;
   logic [15:0]     last_heading = '0;
   longint          cycles    = 0;

   always #1 clock = ~clock;

   planar_odometry_integrator_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   odometry_pose_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_poses (pending_poses)
   );

   // response side: random stalls plus one long hold-off on request
   always @(negedge clock) begin
      if (hold_req) begin
         hold_req  = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= idle_on && ($urandom_range(0, 99) < IDLE_PERCENT);
      end
   end

   // keep the latest heading so the stimulus can steer it
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) last_heading <= rsp_data.heading_out;
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // offer one request, return at the falling edge after it is taken
   task automatic offer_tick(input req_payload_type tick);
      while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= tick;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drive_tick(input int vx, input int vy, input int yaw, input int dt,
                             input bit walk);
      req_payload_type tick;
      tick.vel_x    = vx[15:0];
      tick.vel_y    = vy[15:0];
      tick.yaw_rate = yaw[15:0];
      tick.dt_ticks = dt[15:0];
      tick.walking  = walk;
      offer_tick(tick);
   endtask

   function automatic logic [15:0] random_speed();
      case ($urandom_range(0, 9))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         2:       return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_payload_type random_tick();
      req_payload_type tick;
      tick.vel_x    = random_speed();
      tick.vel_y    = random_speed();
      tick.yaw_rate = random_speed();
      case ($urandom_range(0, 5))
         0:       tick.dt_ticks = '0;
         1:       tick.dt_ticks = 16'hffff;
         2, 3:    tick.dt_ticks = 16'($urandom_range(1, 255));
         default: tick.dt_ticks = 16'($urandom);
      endcase
      tick.walking = $urandom_range(0, 99) < 85;
      return tick;
   endfunction

   // stop offering and let every pose come back
   task automatic drain_poses();
      req_valid <= 1'b0;
      while (pending_poses != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      int delta, half;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: heading zero (cosine of one), field extremes, quadrants
      drive_tick(1000, 0, 0, DT_FULL, 1'b1);
      drive_tick(32767, 0, 0, DT_FULL, 1'b1);
      drive_tick(-32768, 0, 0, DT_FULL, 1'b1);
      drive_tick(0, 32767, 0, DT_FULL, 1'b1);
      drive_tick(0, -32768, 0, DT_FULL, 1'b1);
      drive_tick(32767, 32767, 32767, 0, 1'b1);
      drive_tick(0, 0, 32767, DT_FULL, 1'b1);
      drive_tick(0, 0, -32768, DT_FULL, 1'b1);
      drive_tick(0, 0, -32768, 1, 1'b1);
      drive_tick(0, 0, 1, 1, 1'b1);
      drive_tick(12000, -7000, 16384, DT_FULL, 1'b1);
      drive_tick(12000, -7000, 16384, DT_FULL, 1'b1);
      drive_tick(12000, -7000, 16384, DT_FULL, 1'b1);
      drive_tick(12000, -7000, 16384, DT_FULL, 1'b1);
      drive_tick(20000, 5000, HEADING_45DEG, DT_FULL, 1'b1);
      // not walking: pose holds, still reported; then the same extremes while walking
      drive_tick(32767, -32768, 32767, DT_FULL, 1'b0);
      drive_tick(-32768, -32768, -32768, DT_FULL, 1'b0);
      drive_tick(0, 0, 0, 0, 1'b0);
      drive_tick(32767, 32767, 32767, DT_FULL, 1'b1);
      drive_tick(-32768, -32768, -32768, DT_FULL, 1'b1);
      drive_tick(0, 0, 0, 0, 1'b1);

      // random ticks, a quiet stretch first, then idling and one long hold-off
      for (int n = 0; n < RANDOM_TICKS; n++) begin
         if (n == QUIET_TICKS) idle_on = 1'b1;
         if (n == HOLD_AT_TICK) hold_req = 1'b1;
         offer_tick(random_tick());
      end
      drain_poses();

      // steer the heading to 45 degrees in two exact turns
      delta = int'($signed(16'(HEADING_45DEG - int'(last_heading))));
      half  = delta >>> 1;
      drive_tick(0, 0, half, DT_FULL, 1'b1);
      drive_tick(0, 0, delta - half, DT_FULL, 1'b1);

      // full speed at 45 degrees: largest position steps, back to back
      idle_on = 1'b0;
      repeat (FAST_RUN_TICKS) drive_tick(32767, -32768, 0, DT_FULL, 1'b1);

      // random traffic again to finish
      idle_on = 1'b1;
      repeat (TAIL_TICKS) offer_tick(random_tick());
      drain_poses();

      if (fail_count == 0 && pending_poses == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

@@ planar_odometry_integrator_unit.f @@
rtl/core/odo_pkg.sv
rtl/core/odo_mul.sv
rtl/core/odo_cordic.sv
rtl/core/planar_odometry_integrator_unit.sv
dv/odometry_pose_checker.sv
dv/tb_planar_odometry_integrator_unit.sv
